/* hdl/cli_pkg.sv */
// Shared types and constants of the cubic line interpolator.
`timescale 1ns / 1ps

package cli_pkg;

  localparam int WW = 22;
  localparam int NW = 32;
  localparam int TW = 16;
  localparam int OW = 16;

  typedef logic signed [WW-1:0] cli_wt_t;
  typedef logic signed [NW-1:0] cli_node_t;

  localparam int NODE_START    = 0;
  localparam int NODE_END      = 1;
  localparam int NODE_MID_LOW  = 2;
  localparam int NODE_MID_HIGH = 3;
  localparam int NODES         = 4;

  typedef struct packed {
    logic signed [TW-1:0] param_t;
    cli_node_t            node_start;
    cli_node_t            node_end;
    cli_node_t            node_mid_low;
    cli_node_t            node_mid_high;
  } cli_args_t;

  typedef struct packed {
    logic signed [OW-1:0] weight_start;
    logic signed [OW-1:0] weight_end;
    logic signed [OW-1:0] weight_mid_low;
    logic signed [OW-1:0] weight_mid_high;
    cli_node_t            interp_value;
    cli_node_t            param_slope;
  } cli_result_t;

  typedef struct packed {
    logic                     valid;
    cli_wt_t   [NODES-1:0]    w;
    cli_wt_t   [NODES-1:0]    d;
    cli_node_t [NODES-1:0]    node;
  } cli_coef_t;

endpackage

/* hdl/cli_weights.sv */
// Shape weight and derivative weight pipeline, stages one to five.
`timescale 1ns / 1ps

module cli_weights import cli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cli_args_t args,
  output cli_coef_t coef
);

  localparam logic signed [18:0] S19    = 19'sd16384;
  localparam logic signed [39:0] S2Q    = 40'sd268435456;
  localparam logic signed [39:0] S2Q9   = 40'sd2415919104;
  localparam logic signed [39:0] S2Q27  = 40'sd7247757312;
  localparam logic signed [39:0] RND_D  = 40'sd131072;
  localparam logic signed [55:0] RND_W  = 56'sd2147483648;

  logic v1, v2, v3, v4, v5;

  logic signed [TW-1:0] t1;
  cli_node_t n1 [NODES];
  cli_node_t n2 [NODES];
  cli_node_t n3 [NODES];
  cli_node_t n4 [NODES];
  cli_node_t n5 [NODES];

  logic signed [31:0] tsq, tsq_next;
  logic signed [35:0] ts18, ts18_next;
  logic signed [18:0] lin2 [NODES];
  logic signed [18:0] lin2_next [NODES];
  logic signed [18:0] lin3 [NODES];

  logic signed [36:0] q, q_next;
  logic signed [36:0] p9, p9_next;
  logic signed [39:0] draw [NODES];
  logic signed [39:0] draw_next [NODES];

  logic signed [55:0] prod [NODES];
  logic signed [55:0] prod_next [NODES];
  cli_wt_t d4 [NODES];
  cli_wt_t d4_next [NODES];

  cli_wt_t w5 [NODES];
  cli_wt_t w5_next [NODES];
  cli_wt_t d5 [NODES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 2: square, scaled linear terms
  always_comb begin
    logic signed [35:0] t_ext;
    logic signed [18:0] t19;
    logic signed [18:0] t3;
    t_ext     = {{(36-TW){t1[TW-1]}}, t1};
    t19       = {{(19-TW){t1[TW-1]}}, t1};
    t3        = (t19 <<< 1) + t19;
    tsq_next  = t1 * t1;
    ts18_next = (t_ext <<< 18) + (t_ext <<< 15);
    lin2_next[NODE_START]    = S19 - t19;
    lin2_next[NODE_END]      = S19 + t19;
    lin2_next[NODE_MID_LOW]  = t3 - S19;
    lin2_next[NODE_MID_HIGH] = -t3 - S19;
  end

  // stage 3: quadratic factors and derivative numerators
  always_comb begin
    logic signed [39:0] x;
    logic signed [39:0] x9;
    logic signed [39:0] x27;
    logic signed [39:0] x81;
    logic signed [39:0] y;
    logic signed [39:0] qw;
    logic signed [39:0] pw;
    x   = {{8{tsq[31]}}, tsq};
    y   = {{4{ts18[35]}}, ts18};
    x9  = (x <<< 3) + x;
    x27 = (x <<< 4) + (x <<< 3) + (x <<< 1) + x;
    x81 = (x <<< 6) + (x <<< 4) + x;
    qw  = x9 - S2Q;
    pw  = x9 - S2Q9;
    q_next  = qw[36:0];
    p9_next = pw[36:0];
    draw_next[NODE_START]    = S2Q + y - x27;
    draw_next[NODE_END]      = -S2Q + y + x27;
    draw_next[NODE_MID_LOW]  = -S2Q27 - y + x81;
    draw_next[NODE_MID_HIGH] = S2Q27 - y - x81;
  end

  // stage 4: cubic products, round derivative weights
  always_comb begin
    logic signed [39:0] r;
    prod_next[NODE_START]    = lin3[NODE_START] * q;
    prod_next[NODE_END]      = lin3[NODE_END] * q;
    prod_next[NODE_MID_LOW]  = lin3[NODE_MID_LOW] * p9;
    prod_next[NODE_MID_HIGH] = lin3[NODE_MID_HIGH] * p9;
    for (int i = 0; i < NODES; i++) begin
      r = (draw[i] + RND_D) >>> 18;
      d4_next[i] = r[WW-1:0];
    end
  end

  // stage 5: round shape weights
  always_comb begin
    logic signed [55:0] r;
    for (int i = 0; i < NODES; i++) begin
      r = (prod[i] + RND_W) >>> 32;
      w5_next[i] = r[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    t1                <= args.param_t;
    n1[NODE_START]    <= args.node_start;
    n1[NODE_END]      <= args.node_end;
    n1[NODE_MID_LOW]  <= args.node_mid_low;
    n1[NODE_MID_HIGH] <= args.node_mid_high;
    tsq  <= tsq_next;
    ts18 <= ts18_next;
    q    <= q_next;
    p9   <= p9_next;
    for (int i = 0; i < NODES; i++) begin
      n2[i]   <= n1[i];
      n3[i]   <= n2[i];
      n4[i]   <= n3[i];
      n5[i]   <= n4[i];
      lin2[i] <= lin2_next[i];
      lin3[i] <= lin2[i];
      draw[i] <= draw_next[i];
      prod[i] <= prod_next[i];
      d4[i]   <= d4_next[i];
      d5[i]   <= d4[i];
      w5[i]   <= w5_next[i];
    end
  end

  always_comb begin
    coef.valid = v5;
    for (int i = 0; i < NODES; i++) begin
      coef.w[i]    = w5[i];
      coef.d[i]    = d5[i];
      coef.node[i] = n5[i];
    end
  end

endmodule

/* hdl/cli_accum.sv */
// Weighted node sums and output saturation, stages six to eight.
`timescale 1ns / 1ps

module cli_accum import cli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cli_coef_t   coef,
  output logic        done,
  output cli_result_t result
);

  localparam int PW = WW + NW;
  localparam int RW = PW - 14;
  localparam int SW = RW + 2;

  localparam logic signed [PW-1:0] RND_P  = PW'(8192);
  localparam cli_wt_t              W_MAX  = WW'(32767);
  localparam cli_wt_t              W_MIN  = -WW'(32768);
  localparam logic signed [SW-1:0] S_MAX  = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] S_MIN  = -SW'(64'sd2147483648);

  logic v6, v7;

  logic signed [PW-1:0] pw [NODES];
  logic signed [PW-1:0] pd [NODES];
  logic signed [PW-1:0] pw_next [NODES];
  logic signed [PW-1:0] pd_next [NODES];
  logic signed [OW-1:0] ws6 [NODES];
  logic signed [OW-1:0] ws6_next [NODES];

  logic signed [RW-1:0] rw [NODES];
  logic signed [RW-1:0] rd [NODES];
  logic signed [RW-1:0] rw_next [NODES];
  logic signed [RW-1:0] rd_next [NODES];
  logic signed [OW-1:0] ws7 [NODES];

  cli_result_t result_next;

  function automatic cli_node_t sat_sum(input logic signed [SW-1:0] s);
    cli_node_t r;
    if (s > S_MAX) begin
      r = S_MAX[NW-1:0];
    end else if (s < S_MIN) begin
      r = S_MIN[NW-1:0];
    end else begin
      r = s[NW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v6   <= coef.valid;
      v7   <= v6;
      done <= v7;
    end
  end

  // stage 6: node products, clamp weights
  always_comb begin
    cli_wt_t w;
    cli_wt_t d;
    for (int i = 0; i < NODES; i++) begin
      w = coef.w[i];
      d = coef.d[i];
      pw_next[i] = w * $signed(coef.node[i]);
      pd_next[i] = d * $signed(coef.node[i]);
      if (w > W_MAX) begin
        ws6_next[i] = W_MAX[OW-1:0];
      end else if (w < W_MIN) begin
        ws6_next[i] = W_MIN[OW-1:0];
      end else begin
        ws6_next[i] = w[OW-1:0];
      end
    end
  end

  // stage 7: round products
  always_comb begin
    logic signed [PW-1:0] a;
    logic signed [PW-1:0] b;
    for (int i = 0; i < NODES; i++) begin
      a = (pw[i] + RND_P) >>> 14;
      b = (pd[i] + RND_P) >>> 14;
      rw_next[i] = a[RW-1:0];
      rd_next[i] = b[RW-1:0];
    end
  end

  // stage 8: sum and saturate
  always_comb begin
    logic signed [SW-1:0] sv;
    logic signed [SW-1:0] sd;
    sv = '0;
    sd = '0;
    for (int i = 0; i < NODES; i++) begin
      sv = sv + {{2{rw[i][RW-1]}}, rw[i]};
      sd = sd + {{2{rd[i][RW-1]}}, rd[i]};
    end
    result_next.weight_start    = ws7[NODE_START];
    result_next.weight_end      = ws7[NODE_END];
    result_next.weight_mid_low  = ws7[NODE_MID_LOW];
    result_next.weight_mid_high = ws7[NODE_MID_HIGH];
    result_next.interp_value    = sat_sum(sv);
    result_next.param_slope     = sat_sum(sd);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NODES; i++) begin
      pw[i]  <= pw_next[i];
      pd[i]  <= pd_next[i];
      ws6[i] <= ws6_next[i];
      rw[i]  <= rw_next[i];
      rd[i]  <= rd_next[i];
      ws7[i] <= ws6[i];
    end
    result <= result_next;
  end

endmodule

/* hdl/cubic_line_interpolator.sv */
// Top level of the four-node cubic Lagrange line interpolator.
// Throughput: one item per cycle; eight register stages, multipliers in stages 2, 4 and 6.
// busy is high only while rst is high; the result strobe done lasts one cycle.
// Reset (synchronous, active high) clears every stage valid bit; data is not cleared.
`timescale 1ns / 1ps

module cubic_line_interpolator import cli_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cli_args_t   args,
  output logic        done,
  output cli_result_t result
);

  logic      accept;
  cli_coef_t coef;

  assign busy   = rst;
  assign accept = start && !busy;

  cli_weights u_weights (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .args     (args),
    .coef     (coef)
  );

  cli_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .coef   (coef),
    .done   (done),
    .result (result)
  );

endmodule

/* hdl/cli_checker.sv */
// Port-level assertions for the cubic line interpolator, with bind.
`timescale 1ns / 1ps

module cli_checker import cli_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input cli_args_t   args,
  input logic        done,
  input cli_result_t result
);

  localparam int PIPE_DEPTH = 8;

  logic [3:0]          settle;
  logic signed [17:0]  wsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '0;
    end else if (settle != 4'(PIPE_DEPTH)) begin
      settle <= settle + 4'd1;
    end
  end

  assign wsum = {{2{result.weight_start[OW-1]}}, result.weight_start}
              + {{2{result.weight_end[OW-1]}}, result.weight_end}
              + {{2{result.weight_mid_low[OW-1]}}, result.weight_mid_low}
              + {{2{result.weight_mid_high[OW-1]}}, result.weight_mid_high};

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without an item taken eight cycles earlier");

  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    (settle == 4'(PIPE_DEPTH) && $past(start && !busy, PIPE_DEPTH)) |-> done)
    else $error("item taken but no result after eight cycles");

  a_weights_unity: assert property (@(posedge clk) disable iff (rst)
    (done && $past(args.param_t, PIPE_DEPTH) >= -16'sd16384
          && $past(args.param_t, PIPE_DEPTH) <= 16'sd16384)
    |-> (wsum >= 18'sd16382 && wsum <= 18'sd16386))
    else $error("shape weights do not sum to one");

  a_end_node: assert property (@(posedge clk) disable iff (rst)
    (done && $past(args.param_t, PIPE_DEPTH) == 16'sd16384)
    |-> (result.weight_end == 16'sd16384
         && result.interp_value == $past(args.node_end, PIPE_DEPTH)))
    else $error("value at t=+1 differs from end node");

endmodule

bind cubic_line_interpolator cli_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .args   (args),
  .done   (done),
  .result (result)
);

/* sim/cubic_line_interpolator_tb.sv */
// Self-checking testbench of the cubic line interpolator: directed and random items.
`timescale 1ns / 1ps

module cubic_line_interpolator_tb;
  import cli_pkg::*;

  localparam longint UNIT_T = 16384;
  localparam logic signed [NW-1:0] NODE_MAX = 32'sh7fffffff;
  localparam logic signed [NW-1:0] NODE_MIN = 32'sh80000000;

  logic        clk   = 1'b0;
  logic        rst   = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cli_args_t   args  = '0;
  logic        done;
  cli_result_t result;

  cli_result_t pending_results[$];
  int          fail_count      = 0;
  int          items_sent      = 0;
  int          results_checked = 0;
  int          sender_idle_pct = 0;

  cubic_line_interpolator u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .args   (args),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("** cubic_line_interpolator: FAILED **");
    $finish;
  end

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [OW-1:0] clamp_weight(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[OW-1:0];
  endfunction

  function automatic cli_node_t clamp_word(longint v);
    if (v > 64'sd2147483647) return NODE_MAX;
    if (v < -64'sd2147483648) return NODE_MIN;
    return v[NW-1:0];
  endfunction

  function automatic cli_result_t interpolate(cli_args_t a);
    longint      s, t, q, p, val, slope;
    longint      w[NODES];
    longint      d[NODES];
    longint      n[NODES];
    cli_result_t r;
    s = UNIT_T;
    t = longint'($signed(a.param_t));
    n[NODE_START]    = longint'($signed(a.node_start));
    n[NODE_END]      = longint'($signed(a.node_end));
    n[NODE_MID_LOW]  = longint'($signed(a.node_mid_low));
    n[NODE_MID_HIGH] = longint'($signed(a.node_mid_high));
    q = 9 * t * t - s * s;
    p = t * t - s * s;
    w[NODE_START]    = round_shift((s - t) * q, 32);
    w[NODE_END]      = round_shift((s + t) * q, 32);
    w[NODE_MID_LOW]  = round_shift(9 * p * (3 * t - s), 32);
    w[NODE_MID_HIGH] = round_shift(-9 * p * (3 * t + s), 32);
    d[NODE_START]    = round_shift(s * s + 18 * t * s - 27 * t * t, 18);
    d[NODE_END]      = round_shift(-s * s + 18 * t * s + 27 * t * t, 18);
    d[NODE_MID_LOW]  = round_shift(-27 * s * s - 18 * t * s + 81 * t * t, 18);
    d[NODE_MID_HIGH] = round_shift(27 * s * s - 18 * t * s - 81 * t * t, 18);
    val   = 0;
    slope = 0;
    for (int i = 0; i < NODES; i++) begin
      val   += round_shift(w[i] * n[i], 14);
      slope += round_shift(d[i] * n[i], 14);
    end
    r.weight_start    = clamp_weight(w[NODE_START]);
    r.weight_end      = clamp_weight(w[NODE_END]);
    r.weight_mid_low  = clamp_weight(w[NODE_MID_LOW]);
    r.weight_mid_high = clamp_weight(w[NODE_MID_HIGH]);
    r.interp_value    = clamp_word(val);
    r.param_slope     = clamp_word(slope);
    return r;
  endfunction

  function automatic cli_args_t make_args(int t, cli_node_t n0, cli_node_t n1,
                                          cli_node_t n2, cli_node_t n3);
    cli_args_t a;
    a.param_t       = t[TW-1:0];
    a.node_start    = n0;
    a.node_end      = n1;
    a.node_mid_low  = n2;
    a.node_mid_high = n3;
    return a;
  endfunction

  function automatic int rand_param();
    case ($urandom_range(9))
      0: return int'($signed(16'($urandom())));
      1: begin
        case ($urandom_range(5))
          0: return -32768;
          1: return 32767;
          2: return -16384;
          3: return 16384;
          4: return -5461;
          default: return 5461;
        endcase
      end
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  function automatic cli_node_t rand_node();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: return NODE_MAX;
          1: return NODE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return cli_node_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return cli_node_t'($urandom());
    endcase
  endfunction

  function automatic cli_args_t rand_args();
    return make_args(rand_param(), rand_node(), rand_node(), rand_node(), rand_node());
  endfunction

  task automatic send_item(input cli_args_t a);
    start <= 1'b1;
    args  <= a;
    do @(posedge clk); while (busy);
    pending_results.push_back(interpolate(a));
    items_sent++;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      args  <= rand_args();
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (done) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        cli_result_t exp_r;
        exp_r = pending_results.pop_front();
        results_checked++;
        if (result.weight_start !== exp_r.weight_start) begin
          $error("weight_start expected %0d got %0d", exp_r.weight_start, result.weight_start);
          fail_count++;
        end
        if (result.weight_end !== exp_r.weight_end) begin
          $error("weight_end expected %0d got %0d", exp_r.weight_end, result.weight_end);
          fail_count++;
        end
        if (result.weight_mid_low !== exp_r.weight_mid_low) begin
          $error("weight_mid_low expected %0d got %0d",
                 exp_r.weight_mid_low, result.weight_mid_low);
          fail_count++;
        end
        if (result.weight_mid_high !== exp_r.weight_mid_high) begin
          $error("weight_mid_high expected %0d got %0d",
                 exp_r.weight_mid_high, result.weight_mid_high);
          fail_count++;
        end
        if (result.interp_value !== exp_r.interp_value) begin
          $error("interp_value expected %0d got %0d", exp_r.interp_value, result.interp_value);
          fail_count++;
        end
        if (result.param_slope !== exp_r.param_slope) begin
          $error("param_slope expected %0d got %0d", exp_r.param_slope, result.param_slope);
          fail_count++;
        end
      end
    end
  end

  task automatic test_node_points();
    send_item(make_args(-16384, 32'sd65536, 32'sd131072, 32'sd196608, 32'sd262144));
    send_item(make_args(-5461, 32'sd65536, 32'sd131072, 32'sd196608, 32'sd262144));
    send_item(make_args(0, 32'sd65536, 32'sd131072, 32'sd196608, 32'sd262144));
    send_item(make_args(5461, 32'sd65536, 32'sd131072, 32'sd196608, 32'sd262144));
    send_item(make_args(16384, -32'sd65536, 32'sd131072, -32'sd196608, 32'sd262144));
  endtask

  task automatic test_field_extremes();
    send_item(make_args(-16384, NODE_MAX, NODE_MIN, NODE_MAX, NODE_MIN));
    send_item(make_args(16384, NODE_MIN, NODE_MIN, NODE_MIN, NODE_MIN));
    send_item(make_args(0, NODE_MAX, NODE_MAX, '0, '0));
    send_item(make_args(1, '1, '1, '1, '1));
    send_item(make_args(-1, 32'sd1, -32'sd1, 32'sd1, -32'sd1));
    send_item(make_args(0, '0, '0, '0, '0));
  endtask

  task automatic test_param_out_of_range();
    send_item(make_args(-32768, NODE_MAX, NODE_MAX, NODE_MAX, NODE_MAX));
    send_item(make_args(32767, NODE_MIN, NODE_MAX, NODE_MIN, NODE_MAX));
    send_item(make_args(16385, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536));
    send_item(make_args(-16385, -32'sd65536, 32'sd0, 32'sd65536, 32'sd131072));
    send_item(make_args(24000, 32'sd1000, -32'sd1000, 32'sd2000, -32'sd2000));
  endtask

  task automatic test_sum_saturation();
    send_item(make_args(0, '0, '0, NODE_MAX, NODE_MAX));
    send_item(make_args(0, '0, '0, NODE_MIN, NODE_MIN));
    send_item(make_args(16384, NODE_MAX, NODE_MIN, NODE_MAX, NODE_MIN));
    send_item(make_args(-16384, NODE_MIN, NODE_MAX, NODE_MIN, NODE_MAX));
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    send_item(rand_args());
  endtask

  task automatic test_random_stream(input int count, input int idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_item(rand_args());
    sender_idle_pct = 0;
  endtask

  initial begin
    int wait_cycles;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_node_points();
    test_field_extremes();
    test_param_out_of_range();
    test_sum_saturation();
    test_drain_pause();
    test_random_stream(300, 0);
    test_random_stream(300, 60);
    test_drain_pause();
    test_random_stream(300, 34);
    test_random_stream(300, 0);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d items never produced a result", pending_results.size());
      fail_count++;
    end
    repeat (16) @(posedge clk);
    $display("Sent %0d items, checked %0d results: node points, t beyond +-1,", items_sent,
             results_checked);
    $display("saturated sums and random t/node values under 0, 34 and 60 percent sender gaps.");
    if (fail_count == 0) begin
      $display("** cubic_line_interpolator: PASSED **");
    end else begin
      $display("** cubic_line_interpolator: FAILED **");
    end
    $finish;
  end

endmodule
